// ===== rtl/core/sobel_pkg.sv =====
package sobel_pkg;

   localparam int MAX_WIDTH_PIXELS_DEF = 512;
   localparam int CHANNELS_DEF         = 3;

   localparam int SAMPLE_W       = 8;
   localparam int WIDTH_CFG_W    = 10;
   localparam int ROW_W          = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;
   localparam int HEIGHT_MAX     = 4096;
   localparam int MAG_MAX        = 255;
   localparam int WIDTH_RESET    = 512;
   localparam int HEIGHT_RESET   = 512;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   // Per-item control decoded from the stream position and the drain flag.
   typedef struct packed {
      logic zero_sample;
      logic up_ok;
      logic mid_ok;
      logic emit;
      logic last;
      logic lok;
      logic rok;
   } pos_flags_type;

endpackage

// ===== rtl/core/sobel_if.sv =====
interface sobel_req_if;
   logic                           valid;
   logic                           ready;
   logic [sobel_pkg::SAMPLE_W-1:0] sample;
   logic                           drain;

   modport source (output valid, output sample, output drain, input ready);
   modport sink   (input valid, input sample, input drain, output ready);
endinterface

interface sobel_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sobel_pkg::SAMPLE_W-1:0] magnitude;
   logic                           frame_last;

   modport source (output valid, output magnitude, output frame_last, input ready);
   modport sink   (input valid, input magnitude, input frame_last, output ready);
endinterface

// ===== rtl/core/sobel_ram.sv =====
module sobel_ram #(
   parameter int WIDTH = 2 * sobel_pkg::SAMPLE_W,
   parameter int DEPTH = sobel_pkg::MAX_WIDTH_PIXELS_DEF * sobel_pkg::CHANNELS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sobel_pos.sv =====
module sobel_pos #(
   parameter int MAX_WIDTH_PIXELS = sobel_pkg::MAX_WIDTH_PIXELS_DEF,
   parameter int CHANNELS         = sobel_pkg::CHANNELS_DEF,
   localparam int MAX_BYTES       = MAX_WIDTH_PIXELS * CHANNELS,
   localparam int AW              = $clog2(MAX_BYTES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                drain,
   input  logic [sobel_pkg::WIDTH_CFG_W-1:0]   cfg_width,
   input  logic [sobel_pkg::ROW_W-1:0]         cfg_height,
   output logic [AW-1:0]                       addr,
   output sobel_pkg::pos_flags_type            flags
);

   localparam int COLW = $clog2(MAX_BYTES + 1);
   localparam int PXW  = $clog2(MAX_WIDTH_PIXELS + 1);
   localparam int RW   = sobel_pkg::ROW_W;

   logic [COLW-1:0] col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;

   logic [PXW-1:0]  px_eff;
   logic [COLW-1:0] wb, ch_c, col_a;
   logic [RW-1:0]   h_eff, h_p1, row_a;
   logic [COLW:0]   cc, cc_r;
   logic            last;

   always_comb begin
      if (cfg_width == '0) begin
         px_eff = PXW'(1);
      end else if (32'(cfg_width) > 32'(MAX_WIDTH_PIXELS)) begin
         px_eff = PXW'(MAX_WIDTH_PIXELS);
      end else begin
         px_eff = PXW'(cfg_width);
      end
      wb   = COLW'(32'(px_eff) * CHANNELS);
      ch_c = COLW'(CHANNELS);

      if (cfg_height == '0) begin
         h_eff = RW'(1);
      end else if (32'(cfg_height) > 32'(sobel_pkg::HEIGHT_MAX)) begin
         h_eff = RW'(sobel_pkg::HEIGHT_MAX);
      end else begin
         h_eff = cfg_height;
      end
      h_p1 = h_eff + RW'(1);

      // A finished row wraps first; a row past the flush rows restarts the frame.
      if (col_ff >= wb) begin
         col_a = '0;
         row_a = row_ff + RW'(1);
      end else begin
         col_a = col_ff;
         row_a = row_ff;
      end
      if (row_a > h_p1) begin
         col_a = '0;
         row_a = '0;
      end

      last = (row_a == h_p1) && (col_a == ch_c - COLW'(1));

      flags.zero_sample = drain || (row_a >= h_eff);
      flags.up_ok       = row_a >= RW'(2);
      flags.mid_ok      = row_a != '0;
      flags.emit        = (row_a != '0) && ((row_a > RW'(1)) || (col_a >= ch_c)) &&
                          ((row_a < h_p1) || ((row_a == h_p1) && (col_a <= ch_c - COLW'(1))));
      flags.last        = last;

      // Column of the centre byte, one row plus one pixel behind the stream.
      if (col_a >= ch_c) begin
         cc = {1'b0, col_a} - {1'b0, ch_c};
      end else begin
         cc = {1'b0, col_a} + {1'b0, wb} - {1'b0, ch_c};
      end
      cc_r       = cc + {1'b0, ch_c};
      flags.lok  = cc >= {1'b0, ch_c};
      flags.rok  = cc_r < {1'b0, wb};

      addr = col_a[AW-1:0];

      if (last) begin
         col_in = '0;
         row_in = '0;
      end else begin
         col_in = col_a + COLW'(1);
         row_in = row_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/core/sobel_win.sv =====
module sobel_win #(
   parameter int CHANNELS = sobel_pkg::CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic [sobel_pkg::SAMPLE_W-1:0] up_byte,
   input  logic [sobel_pkg::SAMPLE_W-1:0] mid_byte,
   input  logic [sobel_pkg::SAMPLE_W-1:0] new_byte,
   input  logic                           lok,
   input  logic                           rok,
   output logic [sobel_pkg::SAMPLE_W-1:0] magnitude
);

   localparam int WINC = 2 * CHANNELS + 1;
   localparam int SW   = sobel_pkg::SAMPLE_W;

   logic [SW-1:0] win_ff [3][WINC];
   logic [SW-1:0] win_in [3][WINC];

   logic signed [SW+3:0] ul, ml, ll, uc, lc, ur, mr, lr;
   logic signed [SW+3:0] gx, gy, ax, ay;
   logic        [SW+3:0] sum;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < WINC - 1; i++) begin
            win_in[k][i] = win_ff[k][i+1];
         end
      end
      win_in[0][WINC-1] = up_byte;
      win_in[1][WINC-1] = mid_byte;
      win_in[2][WINC-1] = new_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < WINC; i++) begin
               win_ff[k][i] <= '0;
            end
         end
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      ul = lok ? $signed({4'b0, win_ff[0][0]}) : '0;
      ml = lok ? $signed({4'b0, win_ff[1][0]}) : '0;
      ll = lok ? $signed({4'b0, win_ff[2][0]}) : '0;
      uc = $signed({4'b0, win_ff[0][CHANNELS]});
      lc = $signed({4'b0, win_ff[2][CHANNELS]});
      ur = rok ? $signed({4'b0, win_ff[0][WINC-1]}) : '0;
      mr = rok ? $signed({4'b0, win_ff[1][WINC-1]}) : '0;
      lr = rok ? $signed({4'b0, win_ff[2][WINC-1]}) : '0;

      gx  = (ur + lr + (mr <<< 1)) - (ul + ll + (ml <<< 1));
      gy  = (ll + lr + (lc <<< 1)) - (ul + ur + (uc <<< 1));
      ax  = gx[SW+3] ? -gx : gx;
      ay  = gy[SW+3] ? -gy : gy;
      sum = $unsigned(ax) + $unsigned(ay);

      if (sum > (SW+4)'(sobel_pkg::MAG_MAX)) begin
         magnitude = SW'(sobel_pkg::MAG_MAX);
      end else begin
         magnitude = sum[SW-1:0];
      end
   end

endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// A result appears on rsp_if after the item that completes its neighborhood is accepted,
// passing the line store read, the window update and the output register.
// Throughput: one item per cycle while rsp_if accepts results; the line store read-modify-write
// overlaps across items through a forwarding register on the single memory.
// Reset clears the stream position, the window and the pipeline; registers return to 512x512.
// Line stores are not cleared; the user must write an entry before it is read; not enforced.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH_PIXELS = sobel_pkg::MAX_WIDTH_PIXELS_DEF,
   parameter int CHANNELS         = sobel_pkg::CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sobel_req_if.sink                            req_if,
   sobel_rsp_if.source                          rsp_if,
   input  logic                                 csr_write_en,
   input  logic [sobel_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int MAX_BYTES = MAX_WIDTH_PIXELS * CHANNELS;
   localparam int AW        = $clog2(MAX_BYTES);
   localparam int SW        = sobel_pkg::SAMPLE_W;

   logic [sobel_pkg::WIDTH_CFG_W-1:0] cfg_width_ff;
   logic [sobel_pkg::ROW_W-1:0]       cfg_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= sobel_pkg::WIDTH_CFG_W'(sobel_pkg::WIDTH_RESET);
         cfg_height_ff <= sobel_pkg::ROW_W'(sobel_pkg::HEIGHT_RESET);
      end else if (csr_write_en) begin
         case (sobel_pkg::csr_reg_type'(csr_index))
            sobel_pkg::REG_FRAME_WIDTH: begin
               cfg_width_ff <= csr_wdata[sobel_pkg::WIDTH_CFG_W-1:0];
            end
            sobel_pkg::REG_FRAME_HEIGHT: begin
               cfg_height_ff <= csr_wdata[sobel_pkg::ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline handshake.
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s2_emit_ff, s2_last_ff, s2_lok_ff, s2_rok_ff;
   logic out_free, s2_go, s2_free, s1_go, accept;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s2_go    = s2_valid_ff && (!s2_emit_ff || out_free);
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && s2_free;
   assign accept   = req_if.valid && req_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_go;

   // Stream position and address.
   logic [AW-1:0]            pos_addr;
   sobel_pkg::pos_flags_type pos_flags;

   sobel_pos #(
      .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
      .CHANNELS         (CHANNELS)
   ) u_pos (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .drain      (req_if.drain),
      .cfg_width  (cfg_width_ff),
      .cfg_height (cfg_height_ff),
      .addr       (pos_addr),
      .flags      (pos_flags)
   );

   // Stage 1: line store data arrives, written back with the rows moved up by one.
   logic [AW-1:0]            s1_addr_ff;
   sobel_pkg::pos_flags_type s1_flags_ff;
   logic [SW-1:0]            s1_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
      if (accept) begin
         s1_addr_ff   <= pos_addr;
         s1_flags_ff  <= pos_flags;
         s1_sample_ff <= pos_flags.zero_sample ? '0 : req_if.sample;
      end
   end

   logic [2*SW-1:0] ram_rdata, line_word, wr_word;
   logic [SW-1:0]   up_byte, mid_byte;

   // The most recent write is held so that an item reading the entry written at its
   // own read edge still sees the new contents.
   logic            fwd_valid_ff;
   logic [AW-1:0]   fwd_addr_ff;
   logic [2*SW-1:0] fwd_data_ff;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         line_word = fwd_data_ff;
      end else begin
         line_word = ram_rdata;
      end
      up_byte  = s1_flags_ff.up_ok  ? line_word[2*SW-1:SW] : '0;
      mid_byte = s1_flags_ff.mid_ok ? line_word[SW-1:0]    : '0;
      wr_word  = {mid_byte, s1_sample_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_go) begin
         fwd_valid_ff <= 1'b1;
      end
      if (s1_go) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= wr_word;
      end
   end

   sobel_ram #(
      .WIDTH (2 * SW),
      .DEPTH (MAX_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (pos_addr),
      .rd_data (ram_rdata)
   );

   // Stage 2: the shifted window drives the gradient logic.
   logic [SW-1:0] win_magnitude;

   sobel_win #(
      .CHANNELS (CHANNELS)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_go),
      .up_byte   (up_byte),
      .mid_byte  (mid_byte),
      .new_byte  (s1_sample_ff),
      .lok       (s2_lok_ff),
      .rok       (s2_rok_ff),
      .magnitude (win_magnitude)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_go) begin
         s2_emit_ff <= s1_flags_ff.emit;
         s2_last_ff <= s1_flags_ff.last;
         s2_lok_ff  <= s1_flags_ff.lok;
         s2_rok_ff  <= s1_flags_ff.rok;
      end
   end

   // Output register.
   logic [SW-1:0] rsp_mag_ff;
   logic          rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
      if (out_free && s2_valid_ff && s2_emit_ff) begin
         rsp_mag_ff  <= win_magnitude;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.magnitude  = rsp_mag_ff;
   assign rsp_if.frame_last = rsp_last_ff;

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W     = sobel_pkg::SAMPLE_W;
   localparam int WIDTH_CFG_W  = sobel_pkg::WIDTH_CFG_W;
   localparam int ROW_W        = sobel_pkg::ROW_W;
   localparam int CSR_DATA_W   = sobel_pkg::CSR_DATA_W;
   localparam int CSR_INDEX_W  = sobel_pkg::CSR_INDEX_W;
   localparam int HEIGHT_MAX   = sobel_pkg::HEIGHT_MAX;
   localparam int MAG_MAX      = sobel_pkg::MAG_MAX;
   localparam int WIDTH_RESET  = sobel_pkg::WIDTH_RESET;
   localparam int HEIGHT_RESET = sobel_pkg::HEIGHT_RESET;

   localparam int CH        = sobel_pkg::CHANNELS_DEF;
   localparam int ROW_MAX   = sobel_pkg::MAX_WIDTH_PIXELS_DEF * CH;
   localparam int WIN_COLS  = 2 * CH + 1;
   localparam int SHOWN_MAX = 10;
   localparam int FRAME_ITEMS_MAX = 240;
   localparam int ITEMS_TOTAL     = 1650;
   localparam int CALM_FROM       = 1500;

   typedef struct {
      logic [SAMPLE_W-1:0] magnitude;
      logic                frame_last;
   } edge_result_type;

   typedef enum int {TEX_NOISE, TEX_FAINT, TEX_FLAT} texture_type;

   class edge_scoreboard;
      logic [SAMPLE_W-1:0]    upper_row [ROW_MAX];
      logic [SAMPLE_W-1:0]    middle_row [ROW_MAX];
      logic [SAMPLE_W-1:0]    window [3][WIN_COLS];
      int unsigned            col_pos;
      int unsigned            row_pos;
      int unsigned            written_cols;
      logic [WIDTH_CFG_W-1:0] width_reg;
      logic [ROW_W-1:0]       height_reg;
      edge_result_type        edges_due [$];
      int unsigned            mismatches;
      int unsigned            results_seen;
      int unsigned            frames_closed;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         foreach (window[k, i]) window[k][i] = '0;
         col_pos       = 0;
         row_pos       = 0;
         written_cols  = 0;
         width_reg     = WIDTH_CFG_W'(WIDTH_RESET);
         height_reg    = ROW_W'(HEIGHT_RESET);
         mismatches    = 0;
         results_seen  = 0;
         frames_closed = 0;
      endfunction

      function int unsigned row_bytes_of(logic [WIDTH_CFG_W-1:0] wv);
         int unsigned w;
         w = wv;
         if (w == 0) w = 1;
         if (w > sobel_pkg::MAX_WIDTH_PIXELS_DEF) w = sobel_pkg::MAX_WIDTH_PIXELS_DEF;
         return w * CH;
      endfunction

      function int unsigned frame_rows();
         int unsigned h;
         h = height_reg;
         if (h == 0) h = 1;
         if (h > HEIGHT_MAX) h = HEIGHT_MAX;
         return h;
      endfunction

      // Row that the next item will land in, after the wrap rules.
      function int unsigned upcoming_row();
         int unsigned r;
         r = row_pos;
         if (col_pos >= row_bytes_of(width_reg)) r++;
         if (r > frame_rows() + 1) r = 0;
         return r;
      endfunction

      function bit at_frame_start();
         return (row_pos == 0) && (col_pos == 0);
      endfunction

      function void note_config(sobel_pkg::csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            sobel_pkg::REG_FRAME_WIDTH:  width_reg  = value[WIDTH_CFG_W-1:0];
            sobel_pkg::REG_FRAME_HEIGHT: height_reg = value[ROW_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_item(logic [SAMPLE_W-1:0] sample, logic drain);
         int unsigned         w;
         int unsigned         h;
         int unsigned         col;
         int unsigned         cc;
         logic [SAMPLE_W-1:0] v;
         logic [SAMPLE_W-1:0] up;
         logic [SAMPLE_W-1:0] mid;
         bit                  emit;
         bit                  last;
         bit                  lok;
         bit                  rok;
         int                  ul, ml, ll, uc, lc, ur, mr, lr;
         int                  gx, gy, m;
         edge_result_type     res;
         w = row_bytes_of(width_reg);
         h = frame_rows();
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos > h + 1) begin
            row_pos = 0;
            col_pos = 0;
         end
         col = col_pos;
         v   = (drain || row_pos >= h) ? '0 : sample;
         up  = (row_pos >= 2) ? upper_row[col] : '0;
         mid = (row_pos >= 1) ? middle_row[col] : '0;
         upper_row[col]  = mid;
         middle_row[col] = v;
         if (col + 1 > written_cols) written_cols = col + 1;

         for (int k = 0; k < 3; k++)
            for (int i = 0; i < WIN_COLS - 1; i++) window[k][i] = window[k][i+1];
         window[0][WIN_COLS-1] = up;
         window[1][WIN_COLS-1] = mid;
         window[2][WIN_COLS-1] = v;

         emit = (row_pos >= 1) && (row_pos > 1 || col >= CH) &&
                (row_pos < h + 1 || (row_pos == h + 1 && col <= CH - 1));
         last = (row_pos == h + 1) && (col == CH - 1);

         col_pos = col + 1;
         if (last) begin
            col_pos = 0;
            row_pos = 0;
            frames_closed++;
         end
         if (!emit) return;

         // The centre byte sits one row plus one pixel behind the newest byte.
         cc  = (col >= CH) ? col - CH : col + w - CH;
         lok = cc >= CH;
         rok = cc + CH < w;
         ul  = lok ? int'(window[0][0]) : 0;
         ml  = lok ? int'(window[1][0]) : 0;
         ll  = lok ? int'(window[2][0]) : 0;
         uc  = int'(window[0][CH]);
         lc  = int'(window[2][CH]);
         ur  = rok ? int'(window[0][WIN_COLS-1]) : 0;
         mr  = rok ? int'(window[1][WIN_COLS-1]) : 0;
         lr  = rok ? int'(window[2][WIN_COLS-1]) : 0;
         gx  = -ul - 2 * ml - ll + ur + 2 * mr + lr;
         gy  = -ul - 2 * uc - ur + ll + 2 * lc + lr;
         m   = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         if (m > MAG_MAX) m = MAG_MAX;
         res.magnitude  = SAMPLE_W'(m);
         res.frame_last = last;
         edges_due.push_back(res);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= SHOWN_MAX) $display("ERROR: %s", msg);
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] magnitude, logic frame_last);
         edge_result_type want;
         results_seen++;
         if (edges_due.size() == 0) begin
            flag($sformatf("result %0d arrived with none pending: magnitude=%0d frame_last=%0b",
                           results_seen, magnitude, frame_last));
            return;
         end
         want = edges_due.pop_front();
         if (magnitude !== want.magnitude)
            flag($sformatf("result %0d magnitude: expected %0d, got %0d",
                           results_seen, want.magnitude, magnitude));
         if (frame_last !== want.frame_last)
            flag($sformatf("result %0d frame_last: expected %0b, got %0b",
                           results_seen, want.frame_last, frame_last));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sobel_req_if req ();
   sobel_rsp_if rsp ();

   sobel_edge_magnitude_rgb dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req),
      .rsp_if       (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   edge_scoreboard      sb;
   int unsigned         items_sent;
   int unsigned         csr_writes;
   int unsigned         req_gap_pct;
   int unsigned         rsp_stall_pct;
   bit                  calm;
   texture_type         texture;
   logic [SAMPLE_W-1:0] level;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always begin
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp.ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
         sb.check_result(rsp.magnitude, rsp.frame_last);
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case (texture)
         TEX_FAINT: return level + SAMPLE_W'($urandom_range(0, 12));
         TEX_FLAT: begin
            if ($urandom_range(0, 11) == 0) level = SAMPLE_W'($urandom_range(0, 255));
            return level;
         end
         default: return SAMPLE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic hold_req(int unsigned cycles);
      @(negedge clock);
      req.valid  <= 1'b0;
      req.sample <= SAMPLE_W'($urandom_range(0, 255));
      req.drain  <= 1'($urandom_range(0, 1));
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_item(logic [SAMPLE_W-1:0] sample, logic drain);
      @(negedge clock);
      req.valid  <= 1'b1;
      req.sample <= sample;
      req.drain  <= drain;
      do @(posedge clock); while (req.ready !== 1'b1);
      sb.note_item(sample, drain);
      items_sent++;
      if (!calm && $urandom_range(0, 99) < req_gap_pct) hold_req($urandom_range(1, 16));
   endtask

   // Stop sending until every pending result is out and the pipeline has drained.
   task automatic settle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (sb.edges_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(sobel_pkg::csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.note_config(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Samples in picture rows and drains in flush rows, with some items thrown off.
   task automatic stream_items(int unsigned count, int unsigned noise_pct);
      bit                  flush;
      logic [SAMPLE_W-1:0] s;
      logic                d;
      repeat (count) begin
         flush = sb.upcoming_row() >= sb.frame_rows();
         s     = pick_sample();
         d     = flush;
         if ($urandom_range(0, 99) < noise_pct) d = 1'($urandom_range(0, 1));
         send_item(s, d);
      end
   endtask

   task automatic stream_frames(int unsigned count, int unsigned noise_pct);
      int unsigned target;
      target = sb.frames_closed + count;
      while (sb.frames_closed < target) stream_items(1, noise_pct);
   endtask

   function automatic int unsigned pick_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         2:       return 15;
         default: return 40;
      endcase
   endfunction

   task automatic random_phase();
      logic [WIDTH_CFG_W-1:0] wp;
      logic [CSR_DATA_W-1:0]  hr;
      int unsigned            roll;
      int unsigned            which;
      int unsigned            noise;
      roll = $urandom_range(0, 99);
      if (roll < 70) wp = WIDTH_CFG_W'($urandom_range(0, 6));
      else if (roll < 88) wp = WIDTH_CFG_W'($urandom_range(7, 16));
      else wp = WIDTH_CFG_W'($urandom_range(17, 60));
      roll = $urandom_range(0, 99);
      if (wp > 16) hr = CSR_DATA_W'($urandom_range(0, 3));
      else if (roll < 75) hr = CSR_DATA_W'($urandom_range(0, 6));
      else if (roll < 95) hr = CSR_DATA_W'($urandom_range(7, 20));
      else hr = CSR_DATA_W'($urandom_range(HEIGHT_MAX - 4, 8191));

      settle();
      req_gap_pct   = pick_pct();
      rsp_stall_pct = pick_pct();
      texture       = texture_type'($urandom_range(0, 2));
      level         = SAMPLE_W'($urandom_range(0, 255));
      which         = $urandom_range(0, 2);
      // A wider row in mid-frame would read line store columns never filled.
      if (which != 1 && (sb.at_frame_start() || sb.row_bytes_of(wp) <= sb.written_cols))
         write_csr(sobel_pkg::REG_FRAME_WIDTH, CSR_DATA_W'(wp));
      if (which != 0) write_csr(sobel_pkg::REG_FRAME_HEIGHT, hr);

      noise = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 20) : 0;
      if (sb.frame_rows() * sb.row_bytes_of(sb.width_reg) > FRAME_ITEMS_MAX ||
          $urandom_range(0, 3) == 0)
         stream_items($urandom_range(1, 60), noise);
      else
         stream_frames($urandom_range(1, 2), noise);
   endtask

   initial begin
      sb            = new();
      reset         = 1'b1;
      csr_write_en  = 1'b0;
      csr_index     = sobel_pkg::REG_FRAME_WIDTH;
      csr_wdata     = '0;
      req.valid     = 1'b0;
      req.sample    = '0;
      req.drain     = 1'b0;
      rsp.ready     = 1'b1;
      calm          = 1'b0;
      items_sent    = 0;
      csr_writes    = 0;
      texture       = TEX_NOISE;
      level         = '0;
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Start of a full-size row at the reset settings: nothing comes out yet.
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);

      // The row shrinks below the current column, so the next item opens row 1.
      settle();
      write_csr(sobel_pkg::REG_FRAME_WIDTH, CSR_DATA_W'(1));
      write_csr(sobel_pkg::REG_FRAME_HEIGHT, CSR_DATA_W'(2));
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      repeat (6) send_item(8'h00, 1'b1);

      // Zero registers act as one pixel by one row; a drain inside the picture
      // and a sample in a flush row both count as zero.
      settle();
      write_csr(sobel_pkg::REG_FRAME_WIDTH, CSR_DATA_W'(0));
      write_csr(sobel_pkg::REG_FRAME_HEIGHT, CSR_DATA_W'(0));
      send_item(8'h55, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hAA, 1'b0);
      send_item(8'hC3, 1'b0);
      repeat (5) send_item(8'h00, 1'b1);

      // The widest setting starts a long row; shrinking the row mid-way sends the
      // next item into the flush row, which reads back the columns just written.
      settle();
      write_csr(sobel_pkg::REG_FRAME_WIDTH, CSR_DATA_W'(10'h3FF));
      write_csr(sobel_pkg::REG_FRAME_HEIGHT, CSR_DATA_W'(1));
      stream_items(48, 0);
      settle();
      write_csr(sobel_pkg::REG_FRAME_WIDTH, CSR_DATA_W'(4));
      stream_frames(1, 0);

      // Tallest settings, cut short by a lower height that ends the frame early.
      settle();
      write_csr(sobel_pkg::REG_FRAME_WIDTH, CSR_DATA_W'(2));
      write_csr(sobel_pkg::REG_FRAME_HEIGHT, CSR_DATA_W'(8191));
      stream_items($urandom_range(40, 90), 0);
      settle();
      write_csr(sobel_pkg::REG_FRAME_HEIGHT, CSR_DATA_W'(HEIGHT_MAX));
      texture = TEX_FAINT;
      stream_items($urandom_range(20, 60), 5);
      settle();
      write_csr(sobel_pkg::REG_FRAME_HEIGHT, CSR_DATA_W'(2));
      stream_frames(1, 0);

      while (items_sent < CALM_FROM) random_phase();
      calm = 1'b1;
      while (items_sent < ITEMS_TOTAL) random_phase();

      @(negedge clock);
      req.valid <= 1'b0;
      for (int spin = 0; spin < 100000 && sb.edges_due.size() != 0; spin++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.edges_due.size() != 0)
         sb.flag($sformatf("%0d expected results never arrived", sb.edges_due.size()));

      $display("Sent %0d items, checked %0d edge magnitudes over %0d finished frames.",
               items_sent, sb.results_seen, sb.frames_closed);
      $display("Made %0d register writes, from one-pixel rows to the widest setting.",
               csr_writes);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches in total.", sb.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d results still pending.", sb.edges_due.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
